// File: hw/rtl/tfvs_pkg.sv
// Shared types, constants and saturation helpers for the terrain flow velocity block.
// Used by tfvs_alu and terrain_flow_velocity_shear; depends on nothing.
package tfvs_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_W     = 32;
	localparam int ACC_W      = 47;
	localparam int CR_TOP_BIT = 21;

	localparam logic [30:0] WMAX    = 31'h7FFF_FFFF;
	localparam logic [46:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [30:0] ONE_Q   = 31'(64'd1 << FRAC_BITS);
	localparam logic [31:0] RHO_G   = 32'd9810;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ZX,
		ST_ZY,
		ST_G,
		ST_H,
		ST_SIN,
		ST_Z4,
		ST_INV,
		ST_CR_SQ,
		ST_CR_CUB,
		ST_HH,
		ST_COEF,
		ST_VX_M,
		ST_VX_D,
		ST_VY_M,
		ST_VY_D,
		ST_SPX,
		ST_SPY,
		ST_SP,
		ST_SH_M,
		ST_SH_K,
		ST_RATIO,
		ST_SHSQ,
		ST_P,
		ST_SRC,
		ST_SIG_M,
		ST_SIG_D,
		ST_CSQ,
		ST_CONV,
		ST_ACC,
		ST_FIN
	} st_t;

	function automatic logic [30:0] sat31(input logic [63:0] v);
		return (v > 64'(WMAX)) ? WMAX : v[30:0];
	endfunction

	function automatic logic [46:0] sat47(input logic [47:0] v);
		return (v > 48'(ACC_MAX)) ? ACC_MAX : v[46:0];
	endfunction

	// magnitude limited to the signed word range for the given sign
	function automatic logic [31:0] sat_mag(input logic [63:0] q, input logic neg);
		logic [31:0] lim_neg;
		lim_neg = 32'h8000_0000;
		if (neg)
			return (q > 64'(lim_neg)) ? lim_neg : q[31:0];
		return {1'b0, sat31(q)};
	endfunction

endpackage

// File: hw/rtl/tfvs_alu.sv
// Shared arithmetic unit: 32x32 multiply, 64-step restoring divide,
// 32-step restoring square root. Depends on tfvs_pkg.
module tfvs_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  tfvs_pkg::alu_req_t req,
	input  logic [63:0]       opa,
	input  logic [63:0]       opb,
	output tfvs_pkg::alu_rsp_t rsp,
	output logic [63:0]       result
);
	import tfvs_pkg::*;

	logic        busy_q;
	logic        done_q;
	alu_op_t     op_q;
	logic [5:0]  cnt_q;
	logic [64:0] rem_q;
	logic [63:0] work_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [63:0] res_q;

	logic [64:0] rem_n;
	logic [63:0] work_n;
	logic [63:0] quo_n;
	logic [5:0]  last;
	logic [64:0] dsh;
	logic [35:0] ssh;
	logic [35:0] trial;
	logic        ge;

	always_comb begin
		dsh    = {rem_q[63:0], work_q[63]};
		ssh    = {rem_q[33:0], work_q[63:62]};
		trial  = {2'b00, quo_q[31:0], 2'b01};
		rem_n  = rem_q;
		work_n = work_q;
		ge     = 1'b0;
		last   = 6'd63;
		case (op_q)
			ALU_DIV: begin
				ge     = dsh >= {1'b0, dvs_q};
				rem_n  = ge ? (dsh - {1'b0, dvs_q}) : dsh;
				work_n = {work_q[62:0], 1'b0};
				last   = 6'd63;
			end
			ALU_SQRT: begin
				ge     = ssh >= trial;
				rem_n  = {29'd0, (ge ? (ssh - trial) : ssh)};
				work_n = {work_q[61:0], 2'b00};
				last   = 6'd31;
			end
			default: begin
				ge = 1'b0;
			end
		endcase
		quo_n = {quo_q[62:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q   <= req.op;
				cnt_q  <= '0;
				busy_q <= (req.op != ALU_MUL);
				done_q <= (req.op == ALU_MUL);
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= opa;
			dvs_q  <= opb;
			rem_q  <= '0;
			quo_q  <= '0;
			if (req.op == ALU_MUL)
				res_q <= opa[31:0] * opb[31:0];
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
			quo_q  <= quo_n;
			if (cnt_q == last)
				res_q <= quo_n;
		end
	end

	assign rsp.done = done_q;
	assign result   = res_q;

endmodule

// File: hw/rtl/terrain_flow_velocity_shear.sv
// Terrain flow velocity and shear terms per raster cell, fixed point Q16.16.
// Top level: sequencer and datapath registers around tfvs_alu. Depends on tfvs_pkg.
//
// Usage:
//  Input channel in_valid/in_ready carries one cell per transaction; in_ready is
//  high only while the sequencer is idle. Output channel out_valid/out_ready
//  carries one result per cell from an output register, so the next cell may be
//  taken and worked on while a finished result waits for the receiver.
//  Config channel cfg_valid/cfg_ready writes depth_mode; cfg_ready is always high.
//  A nodata or zero-roughness cell goes from idle straight to the final state and
//  waits there for the output register. Other cells run the arithmetic steps, which
//  flat cells and weak shear partly skip; a depth-mode cell also runs the cube-root
//  search for depth^(2/3), taking 22 multiply pairs. All operations on the shared
//  unit are issued one after another.
//  The sequencer takes one cell at a time and returns to idle between cells.
//  If the receiver stalls, a finished cell waits in the sequencer until the output
//  register is free; no transaction is dropped.
//  Reset clears depth_mode, the running sums and maxima and all handshake state.
module terrain_flow_velocity_shear (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        depth_mode,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cell_defined,
	input  logic        first_cell,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic [30:0] manning_n,
	input  logic [30:0] water_depth,
	input  logic [30:0] crit_shear,
	input  logic [30:0] detach_coef,
	input  logic [30:0] transport_coef,
	input  logic [30:0] source_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        cell_valid,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic [30:0] speed,
	output logic [30:0] source_rate,
	output logic [30:0] reaction_coef,
	output logic [30:0] conveyance,
	output logic        roughness_error,
	output logic [46:0] speed_total,
	output logic [30:0] speed_peak,
	output logic [30:0] reaction_peak,
	output logic [46:0] source_total
);
	import tfvs_pkg::*;

	st_t         state_q, state_n;
	logic        dm_q;
	logic        issued_q;
	logic        out_valid_q;

	logic        valid_q, rerr_q, nx_q, ny_q;
	logic [31:0] ax_q, ay_q;
	logic [30:0] n_q, depth_q, tau_q, dc_q, ct_q;
	logic [63:0] prod_q;
	logic [31:0] g_q, h_q;
	logic [16:0] sinsl_q;
	logic [23:0] zd4_q;
	logic [30:0] inv_n_q, hh_q, coef_q;
	logic [21:0] r_q;
	logic [4:0]  bit_q;
	logic [27:0] t_q;
	logic [31:0] mx_q, my_q, shm_q;
	logic [30:0] shear_q, diff_q, ratio_q;
	logic [23:0] shsq_q;
	logic [47:0] p_q;
	logic [31:0] vx_q, vy_q;
	logic [30:0] sp_q, src_q, sig_q, conv_q;

	logic [46:0] speed_acc_q, source_acc_q;
	logic [30:0] speed_max_q, reaction_max_q;

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;
	logic [63:0] opa, opb, alu_res;
	logic        busy_st;
	logic        done;
	logic        in_acc;
	logic        out_load;
	logic [21:0] cand;
	logic [30:0] shear_n;
	logic [31:0] mag_n;
	logic        neg_n;
	st_t         vel_skip;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign done      = alu_rsp.done;
	assign cand      = r_q | (22'd1 << bit_q);
	assign shear_n   = sat31(64'(alu_res[31:0]) * 64'(1) > 64'(WMAX) ? 64'(WMAX) : alu_res);
	assign neg_n     = (state_q == ST_VX_D) ? nx_q : ny_q;
	assign mag_n     = sat_mag(alu_res, neg_n);
	assign vel_skip  = dm_q ? ST_SH_M : ST_CSQ;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	tfvs_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (opa),
		.opb    (opb),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (alu_req.start)
				issued_q <= 1'b1;
			else if (done)
				issued_q <= 1'b0;
		end
	end

	always_comb begin
		state_n     = state_q;
		busy_st     = 1'b1;
		alu_req.op  = ALU_MUL;
		opa         = '0;
		opb         = '0;
		unique case (state_q)
			ST_IDLE: begin
				busy_st = 1'b0;
				if (in_valid) begin
					if (!cell_defined || manning_n == '0)
						state_n = ST_FIN;
					else
						state_n = ST_ZX;
				end
			end
			ST_ZX: begin
				opa = 64'(ax_q); opb = 64'(ax_q);
				if (done) state_n = ST_ZY;
			end
			ST_ZY: begin
				opa = 64'(ay_q); opb = 64'(ay_q);
				if (done) state_n = ST_G;
			end
			ST_G: begin
				alu_req.op = ALU_SQRT; opa = prod_q;
				if (done) state_n = ST_H;
			end
			ST_H: begin
				alu_req.op = ALU_SQRT; opa = prod_q + (64'd1 << (2 * FRAC_BITS));
				if (done) state_n = ST_SIN;
			end
			ST_SIN: begin
				alu_req.op = ALU_DIV; opa = 64'(g_q) << FRAC_BITS; opb = 64'(h_q);
				if (done) state_n = ST_Z4;
			end
			ST_Z4: begin
				alu_req.op = ALU_SQRT; opa = 64'(g_q) << FRAC_BITS;
				if (done) state_n = ST_INV;
			end
			ST_INV: begin
				alu_req.op = ALU_DIV; opa = 64'd1 << (2 * FRAC_BITS); opb = 64'(n_q);
				if (done) state_n = dm_q ? ST_CR_SQ : ST_COEF;
			end
			ST_CR_SQ: begin
				opa = 64'(cand); opb = 64'(cand);
				if (done) state_n = ST_CR_CUB;
			end
			ST_CR_CUB: begin
				opa = 64'(t_q); opb = 64'(cand);
				if (done) state_n = (bit_q == '0) ? ST_HH : ST_CR_SQ;
			end
			ST_HH: begin
				opa = 64'(r_q); opb = 64'(r_q);
				if (done) state_n = ST_COEF;
			end
			ST_COEF: begin
				opa = 64'(hh_q); opb = 64'(inv_n_q);
				if (done) state_n = (g_q != '0 && zd4_q != '0) ? ST_VX_M : vel_skip;
			end
			ST_VX_M: begin
				opa = 64'(coef_q); opb = 64'(ax_q);
				if (done) state_n = ST_VX_D;
			end
			ST_VX_D: begin
				alu_req.op = ALU_DIV; opa = prod_q; opb = 64'(zd4_q);
				if (done) state_n = ST_VY_M;
			end
			ST_VY_M: begin
				opa = 64'(coef_q); opb = 64'(ay_q);
				if (done) state_n = ST_VY_D;
			end
			ST_VY_D: begin
				alu_req.op = ALU_DIV; opa = prod_q; opb = 64'(zd4_q);
				if (done) state_n = ST_SPX;
			end
			ST_SPX: begin
				opa = 64'(mx_q); opb = 64'(mx_q);
				if (done) state_n = ST_SPY;
			end
			ST_SPY: begin
				opa = 64'(my_q); opb = 64'(my_q);
				if (done) state_n = ST_SP;
			end
			ST_SP: begin
				alu_req.op = ALU_SQRT; opa = prod_q;
				if (done) state_n = vel_skip;
			end
			ST_SH_M: begin
				opa = 64'(depth_q); opb = 64'(sinsl_q);
				if (done) state_n = ST_SH_K;
			end
			ST_SH_K: begin
				opa = 64'(shm_q); opb = 64'(RHO_G);
				if (done)
					state_n = (shear_n <= tau_q || ct_q == '0) ? ST_CSQ : ST_RATIO;
			end
			ST_RATIO: begin
				alu_req.op = ALU_DIV; opa = 64'(dc_q) << FRAC_BITS; opb = 64'(ct_q);
				if (done) state_n = ST_SHSQ;
			end
			ST_SHSQ: begin
				alu_req.op = ALU_SQRT; opa = 64'(shear_q) << FRAC_BITS;
				if (done) state_n = ST_P;
			end
			ST_P: begin
				opa = 64'(shear_q); opb = 64'(shsq_q);
				if (done) state_n = ST_SRC;
			end
			ST_SRC: begin
				opa = 64'(dc_q); opb = 64'(diff_q);
				if (done) state_n = ST_SIG_M;
			end
			ST_SIG_M: begin
				opa = 64'(ratio_q); opb = 64'(diff_q);
				if (done) state_n = (p_q == '0) ? ST_CSQ : ST_SIG_D;
			end
			ST_SIG_D: begin
				alu_req.op = ALU_DIV; opa = prod_q; opb = 64'(p_q);
				if (done) state_n = ST_CSQ;
			end
			ST_CSQ: begin
				alu_req.op = ALU_SQRT; opa = 64'(sinsl_q) << FRAC_BITS;
				if (done) state_n = ST_CONV;
			end
			ST_CONV: begin
				opa = 64'(inv_n_q); opb = 64'(alu_res[16:0]);
				if (done) state_n = ST_ACC;
			end
			ST_ACC: begin
				busy_st = 1'b0;
				state_n = ST_FIN;
			end
			ST_FIN: begin
				busy_st = 1'b0;
				if (!out_valid_q || out_ready)
					state_n = ST_IDLE;
			end
			default: begin
				busy_st = 1'b0;
				state_n = ST_IDLE;
			end
		endcase
		alu_req.start = busy_st && !issued_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			valid_q <= cell_defined;
			rerr_q  <= cell_defined && (manning_n == '0);
			nx_q    <= grad_x[31];
			ny_q    <= grad_y[31];
			ax_q    <= grad_x[31] ? (32'd0 - grad_x) : grad_x;
			ay_q    <= grad_y[31] ? (32'd0 - grad_y) : grad_y;
			n_q     <= manning_n;
			depth_q <= water_depth;
			tau_q   <= crit_shear;
			dc_q    <= detach_coef;
			ct_q    <= transport_coef;
			vx_q    <= '0;
			vy_q    <= '0;
			sp_q    <= '0;
			sig_q   <= '0;
			conv_q  <= '0;
			src_q   <= (dm_q || !cell_defined || manning_n == '0) ? '0 : source_in;
			r_q     <= '0;
			bit_q   <= 5'(CR_TOP_BIT);
			hh_q    <= ONE_Q;
		end
		if (done) begin
			case (state_q)
				ST_ZX:     prod_q  <= alu_res;
				ST_ZY:     prod_q  <= prod_q + alu_res;
				ST_G:      g_q     <= alu_res[31:0];
				ST_H:      h_q     <= alu_res[31:0];
				ST_SIN:    sinsl_q <= alu_res[16:0];
				ST_Z4:     zd4_q   <= alu_res[23:0];
				ST_INV:    inv_n_q <= sat31(alu_res);
				ST_CR_SQ:  t_q     <= alu_res[43:16];
				ST_CR_CUB: begin
					if (alu_res <= {17'd0, depth_q, 16'hFFFF})
						r_q <= cand;
					bit_q <= bit_q - 5'd1;
				end
				ST_HH:     hh_q    <= sat31(alu_res >> FRAC_BITS);
				ST_COEF:   coef_q  <= sat31(alu_res >> FRAC_BITS);
				ST_VX_M, ST_VY_M, ST_SIG_M: prod_q <= alu_res;
				ST_VX_D: begin
					mx_q <= mag_n;
					vx_q <= nx_q ? (32'd0 - mag_n) : mag_n;
				end
				ST_VY_D: begin
					my_q <= mag_n;
					vy_q <= ny_q ? (32'd0 - mag_n) : mag_n;
				end
				ST_SPX:    prod_q  <= alu_res;
				ST_SPY:    prod_q  <= prod_q + alu_res;
				ST_SP:     sp_q    <= sat31(alu_res);
				ST_SH_M:   shm_q   <= alu_res[47:16];
				ST_SH_K: begin
					shear_q <= shear_n;
					diff_q  <= shear_n - tau_q;
				end
				ST_RATIO:  ratio_q <= sat31(alu_res);
				ST_SHSQ:   shsq_q  <= alu_res[23:0];
				ST_P:      p_q     <= alu_res[63:16];
				ST_SRC:    src_q   <= sat31(alu_res >> FRAC_BITS);
				ST_SIG_D:  sig_q   <= sat31(alu_res);
				ST_CONV:   conv_q  <= sat31(alu_res >> FRAC_BITS);
				default: begin
				end
			endcase
		end
		if (state_q == ST_SIG_M && done && p_q == '0)
			sig_q <= WMAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dm_q           <= 1'b0;
			speed_acc_q    <= '0;
			source_acc_q   <= '0;
			speed_max_q    <= '0;
			reaction_max_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid)
				dm_q <= depth_mode;
			if (in_acc && first_cell) begin
				speed_acc_q    <= '0;
				source_acc_q   <= '0;
				speed_max_q    <= '0;
				reaction_max_q <= '0;
			end else if (state_q == ST_ACC) begin
				speed_acc_q  <= sat47({1'b0, speed_acc_q} + 48'(sp_q));
				source_acc_q <= sat47({1'b0, source_acc_q} + 48'(src_q));
				if (sp_q > speed_max_q)
					speed_max_q <= sp_q;
				if (sig_q > reaction_max_q)
					reaction_max_q <= sig_q;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_valid      <= valid_q;
			vel_x           <= vx_q;
			vel_y           <= vy_q;
			speed           <= sp_q;
			source_rate     <= src_q;
			reaction_coef   <= sig_q;
			conveyance      <= conv_q;
			roughness_error <= rerr_q;
			speed_total     <= valid_q ? speed_acc_q : '0;
			speed_peak      <= valid_q ? speed_max_q : '0;
			reaction_peak   <= valid_q ? reaction_max_q : '0;
			source_total    <= valid_q ? source_acc_q : '0;
		end
	end

	assign out_valid = out_valid_q;

	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cell_valid |-> vel_x == '0 && speed_total == '0 && source_total == '0)
		else $error("nodata cell carries non-zero results");

	a_rough_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && roughness_error |-> speed == '0 && source_rate == '0 && conveyance == '0)
		else $error("zero roughness cell carries non-zero results");

	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> issued_q)
		else $error("arithmetic unit finished without a request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

endmodule

// File: tb/tfvs_checker.sv
// Checker for terrain_flow_velocity_shear: watches the config, input and output channels,
// predicts each result in Q16.16 and compares field by field. Depends on nothing but the
// port widths of the block.
module tfvs_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               depth_mode,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               cell_defined,
	input  logic               first_cell,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic [30:0]        manning_n,
	input  logic [30:0]        water_depth,
	input  logic [30:0]        crit_shear,
	input  logic [30:0]        detach_coef,
	input  logic [30:0]        transport_coef,
	input  logic [30:0]        source_in,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               cell_valid,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [30:0]        speed,
	input  logic [30:0]        source_rate,
	input  logic [30:0]        reaction_coef,
	input  logic [30:0]        conveyance,
	input  logic               roughness_error,
	input  logic [46:0]        speed_total,
	input  logic [30:0]        speed_peak,
	input  logic [30:0]        reaction_peak,
	input  logic [46:0]        source_total,
	output int                 fails,
	output int                 pending,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          FB      = 16;
	localparam logic [63:0] W_MAX   = 64'h7FFF_FFFF;
	localparam logic [63:0] SUM_MAX = (64'd1 << 47) - 64'd1;
	localparam logic [63:0] RHOG    = 64'd9810;

	typedef struct packed {
		logic        valid;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [30:0] sp;
		logic [30:0] src;
		logic [30:0] sig;
		logic [30:0] conv;
		logic        rerr;
		logic [46:0] sp_tot;
		logic [30:0] sp_pk;
		logic [30:0] sig_pk;
		logic [46:0] src_tot;
	} cell_res_t;

	cell_res_t   flow_results[$];
	logic        mode_q;
	logic [63:0] speed_sum, source_sum, speed_top, react_top;

	function automatic logic [63:0] sat(input logic [63:0] v);
		return (v > W_MAX) ? W_MAX : v;
	endfunction

	function automatic logic [63:0] root(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] depth_pow(input logic [63:0] d);
		logic [63:0] lim, r, c, t;
		lim = ((d + 1) << FB) - 1;
		r = 0;
		for (int bit_i = 27; bit_i >= 0; bit_i--) begin
			c = r | (64'd1 << bit_i);
			t = (c * c) >> FB;
			if (t <= lim / c)
				r = c;
		end
		return sat((r * r) >> FB);
	endfunction

	function automatic logic [31:0] signed_bits(input logic [63:0] m, input logic neg,
			output logic [63:0] m_sat);
		logic [63:0] t;
		if (neg) begin
			m_sat = (m > W_MAX + 1) ? W_MAX + 1 : m;
			t = (64'd1 << 32) - m_sat;
			return (m_sat == 0) ? 32'd0 : t[31:0];
		end
		m_sat = sat(m);
		return m_sat[31:0];
	endfunction

	function automatic logic [63:0] acc_add(input logic [63:0] a, input logic [63:0] b);
		return (a + b > SUM_MAX) ? SUM_MAX : a + b;
	endfunction

	function automatic cell_res_t predict_cell();
		cell_res_t   e;
		logic        nx, ny;
		logic [63:0] ax, ay, n, d, zd2, g, h, sinsl, zd4, inv_n, hh, coef, mx, my;
		logic [63:0] sp, src, sig, conv, shear, diff, ratio, p;
		e = '0;
		if (first_cell) begin
			speed_sum = 0;
			source_sum = 0;
			speed_top = 0;
			react_top = 0;
		end
		if (!cell_defined)
			return e;
		e.valid = 1'b1;
		n = 64'(manning_n);
		if (n == 0) begin
			e.rerr = 1'b1;
		end else begin
			nx = grad_x[31];
			ny = grad_y[31];
			ax = nx ? (64'd1 << 32) - 64'(unsigned'(grad_x)) : 64'(unsigned'(grad_x));
			ay = ny ? (64'd1 << 32) - 64'(unsigned'(grad_y)) : 64'(unsigned'(grad_y));
			d = 64'(water_depth);
			zd2 = ax * ax + ay * ay;
			g = root(zd2);
			h = root(zd2 + (64'd1 << (2 * FB)));
			sinsl = (g << FB) / h;
			zd4 = root(g << FB);
			inv_n = sat((64'd1 << (2 * FB)) / n);
			hh = mode_q ? depth_pow(d) : sat(64'd1 << FB);
			sp = 0;
			if (g != 0 && zd4 != 0) begin
				coef = sat((hh * inv_n) >> FB);
				e.vx = signed_bits((coef * ax) / zd4, nx, mx);
				e.vy = signed_bits((coef * ay) / zd4, ny, my);
				sp = sat(root(mx * mx + my * my));
			end
			if (mode_q) begin
				shear = sat(RHOG * ((d * sinsl) >> FB));
				if (shear <= 64'(crit_shear) || transport_coef == 0) begin
					src = 0;
					sig = 0;
				end else begin
					diff = shear - 64'(crit_shear);
					ratio = sat((64'(detach_coef) << FB) / 64'(transport_coef));
					p = (shear * root(shear << FB)) >> FB;
					src = sat((64'(detach_coef) * diff) >> FB);
					sig = (p == 0) ? W_MAX : sat((ratio * diff) / p);
				end
			end else begin
				src = 64'(source_in);
				sig = 0;
			end
			conv = sat((inv_n * root(sinsl << FB)) >> FB);
			speed_sum = acc_add(speed_sum, sp);
			source_sum = acc_add(source_sum, src);
			if (sp > speed_top)
				speed_top = sp;
			if (sig > react_top)
				react_top = sig;
			e.sp = sp[30:0];
			e.src = src[30:0];
			e.sig = sig[30:0];
			e.conv = conv[30:0];
		end
		e.sp_tot = speed_sum[46:0];
		e.sp_pk = speed_top[30:0];
		e.sig_pk = react_top[30:0];
		e.src_tot = source_sum[46:0];
		return e;
	endfunction

	task automatic compare(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_res_t e;
		if (!arst_n) begin
			mode_q = 1'b0;
			speed_sum = 0;
			source_sum = 0;
			speed_top = 0;
			react_top = 0;
			flow_results.delete();
			fails = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q = depth_mode;
			if (in_valid && in_ready)
				flow_results.push_back(predict_cell());
			if (out_valid && out_ready) begin
				if (flow_results.size() == 0) begin
					$error("unexpected transaction on the output channel");
					fails++;
				end else begin
					e = flow_results.pop_front();
					compare("cell_valid", e.valid, cell_valid);
					compare("vel_x", e.vx, unsigned'(vel_x));
					compare("vel_y", e.vy, unsigned'(vel_y));
					compare("speed", e.sp, speed);
					compare("source_rate", e.src, source_rate);
					compare("reaction_coef", e.sig, reaction_coef);
					compare("conveyance", e.conv, conveyance);
					compare("roughness_error", e.rerr, roughness_error);
					compare("speed_total", e.sp_tot, speed_total);
					compare("speed_peak", e.sp_pk, speed_peak);
					compare("reaction_peak", e.sig_pk, reaction_peak);
					compare("source_total", e.src_tot, source_total);
					checked++;
				end
			end
			pending = flow_results.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the terrain_flow_velocity_shear testbench: clock, reset, stimulus and verdict.
// Depends on the block and on tfvs_checker, which predicts and compares.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic MODE_PLAIN = 1'b0;
	localparam logic MODE_DEPTH = 1'b1;
	localparam int   CYCLE_LIMIT = 4_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0, depth_mode = 1'b0;
	logic               cfg_ready;
	logic               in_valid = 1'b0, in_ready;
	logic               cell_defined = 1'b0, first_cell = 1'b0;
	logic signed [31:0] grad_x = '0, grad_y = '0;
	logic [30:0]        manning_n = '0, water_depth = '0, crit_shear = '0;
	logic [30:0]        detach_coef = '0, transport_coef = '0, source_in = '0;
	logic               out_valid, out_ready = 1'b0;
	logic               cell_valid, roughness_error;
	logic signed [31:0] vel_x, vel_y;
	logic [30:0]        speed, source_rate, reaction_coef, conveyance, speed_peak, reaction_peak;
	logic [46:0]        speed_total, source_total;
	int                 fails, pending, checked;
	int                 send_idle = 0, recv_idle = 0, cycles = 0, sent = 0;

	always #4 clk = ~clk;

	terrain_flow_velocity_shear dut (.*);
	tfvs_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_mode(input logic m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		depth_mode <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_cell(input logic def, input logic first, input logic [31:0] gx,
			input logic [31:0] gy, input logic [30:0] n, input logic [30:0] d,
			input logic [30:0] tau, input logic [30:0] dc, input logic [30:0] ct,
			input logic [30:0] src);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cell_defined <= def;
		first_cell <= first;
		grad_x <= gx;
		grad_y <= gy;
		manning_n <= n;
		water_depth <= d;
		crit_shear <= tau;
		detach_coef <= dc;
		transport_coef <= ct;
		source_in <= src;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [31:0] rand_scaled();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(3))
			0: v = v >> $urandom_range(31);
			1: v = $signed(v) >>> $urandom_range(24, 31);
			default: v = $signed(v) >>> $urandom_range(8, 20);
		endcase
		return v;
	endfunction

	function automatic logic [30:0] rand_field();
		return 31'($urandom() >> $urandom_range(1, 31));
	endfunction

	task automatic send_random();
		logic [30:0] n, ct;
		n = ($urandom_range(19) == 0) ? 31'd0 : rand_field();
		ct = ($urandom_range(9) == 0) ? 31'd0 : rand_field();
		send_cell($urandom_range(15) != 0, $urandom_range(40) == 0, rand_scaled(),
			rand_scaled(), n, rand_field(), ($urandom_range(3) == 0) ? rand_field() :
			31'($urandom_range(65535)), rand_field(), ct, rand_field());
	endtask

	task automatic run_directed(input logic m);
		write_mode(m);
		send_cell(1, 1, 32'h0001_0000, 32'h0000_8000, 31'h0000_0800, 31'h0000_8000,
			31'd100, 31'h0001_0000, 31'h0002_0000, 31'h0000_4000);
		send_cell(1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF,
			31'd0, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
		send_cell(1, 0, 32'h0, 32'h0, 31'h0001_0000, 31'h0001_0000,
			31'd0, 31'h0001_0000, 31'h0001_0000, 31'd77);
		send_cell(1, 0, 32'hFFFF_0000, 32'h0, 31'd0, 31'h0001_0000,
			31'd0, 31'h0001_0000, 31'h0001_0000, 31'd5);
		send_cell(0, 0, 32'h1234_5678, 32'h8765_4321, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_cell(1, 0, 32'h0003_0000, 32'hFFFC_0000, 31'h7FFF_FFFF, 31'h0005_0000,
			31'h7FFF_FFFF, 31'h0001_0000, 31'h0001_0000, 31'd0);
		send_cell(1, 0, 32'h0000_2000, 32'h0000_1000, 31'h0000_0400, 31'h0002_0000,
			31'd10, 31'h0000_8000, 31'd0, 31'd9);
		send_cell(1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0000_0001, 31'd1,
			31'd0, 31'd1, 31'h7FFF_FFFF, 31'd0);
		send_cell(1, 0, 32'hFFFF_FFFF, 32'h0000_0001, 31'h0000_1000, 31'h0010_0000,
			31'd5, 31'h0000_4000, 31'h0000_0100, 31'd1);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		send_cell(0, 1, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0, 31'h0, 31'h0, 31'h0);
		send_cell(1, 0, 32'h0000_4000, 32'hFFFF_C000, 31'h0000_2000, 31'h0000_0100,
			31'd0, 31'h0000_2000, 31'h0000_1000, 31'h0000_0100);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed(MODE_PLAIN);
		run_directed(MODE_DEPTH);
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin send_idle = 31; recv_idle = 54; end
				1: begin send_idle = 54; recv_idle = 31; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			in_valid <= 1'b0;
			write_mode((ph % 2 == 0) ? MODE_DEPTH : MODE_PLAIN);
			for (int i = 0; i < 125; i++)
				send_random();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d cells (directed and random, both modes, three idling regimes);",
			sent);
		$display("checked %0d results field by field.", checked);
		if (fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
